/* sv/fourth_rank_tensor_rotation_core_macros.svh */
// Assertion macros shared by the tensor rotation RTL.
`ifndef FOURTH_RANK_TENSOR_ROTATION_CORE_MACROS_SVH
`define FOURTH_RANK_TENSOR_ROTATION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FRTR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frtr check failed");
`define FRTR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frtr check failed");
`else
`define FRTR_ASSERT_IMP(lbl, ante, cons)
`define FRTR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* sv/frtr_pkg.sv */
// Shared constants, types and index helpers for the tensor rotation core.
`timescale 1ns / 1ps
package frtr_pkg;

    localparam int DIMENSION  = 3;
    localparam int RANK       = 4;
    localparam int ROT_SIZE   = DIMENSION * DIMENSION;
    localparam int TEN_SIZE   = ROT_SIZE * ROT_SIZE;
    localparam int ROT_AW     = $clog2(ROT_SIZE);
    localparam int TEN_AW     = $clog2(TEN_SIZE);
    localparam int DIG_W      = $clog2(DIMENSION);
    localparam int PASS_W     = $clog2(RANK);

    localparam int IDX_W      = 7;
    localparam int VAL_W      = 32;
    localparam int REQ_W      = 2;

    localparam int S_TDATA_W  = ((IDX_W + VAL_W + 7) / 8) * 8;
    localparam int S_TUSER_W  = REQ_W;
    localparam int M_TDATA_W  = ((IDX_W + VAL_W + 7) / 8) * 8;
    localparam int M_TUSER_W  = 1;

    localparam int LIMB_W     = 32;
    localparam int LIMBS      = 6;
    localparam int TERM_LIMBS = RANK + 1;
    localparam int LIMB_IW    = $clog2(TERM_LIMBS);
    localparam int ACC_W      = LIMBS * LIMB_W;
    localparam int FRAC_DROP  = RANK * 30;
    localparam int HI_W       = ACC_W - FRAC_DROP;

    localparam logic [VAL_W-1:0] SAT_POS = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SAT_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    localparam int unsigned PLACE [RANK] = '{DIMENSION * DIMENSION * DIMENSION,
                                             DIMENSION * DIMENSION, DIMENSION, 1};

    typedef enum logic [REQ_W-1:0] {
        REQ_ROT_WR = 2'd0,
        REQ_TEN_WR = 2'd1,
        REQ_READ   = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_INIT,
        ST_MUL,
        ST_FETCH,
        ST_ACC,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef logic [RANK-1:0][DIG_W-1:0] digits_t;

    typedef struct packed {
        logic               clear;
        logic               init;
        logic               fetch;
        logic               mul;
        logic               last_limb;
        logic [LIMB_IW-1:0] limb;
        logic               acc;
        logic               round;
    } dp_cmd_t;

    function automatic digits_t split_index(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] rem;
        digits_t          dg;
        rem = idx;
        dg  = '0;
        for (int p = 0; p < RANK; p++) begin
            for (int k = 1; k < DIMENSION; k++) begin
                if (32'(rem) >= k * PLACE[p]) begin
                    dg[p] = DIG_W'(k);
                end
            end
            rem = rem - IDX_W'(32'(dg[p]) * PLACE[p]);
        end
        return dg;
    endfunction

    function automatic digits_t incr_digits(input digits_t d);
        digits_t r;
        logic    carry;
        r     = d;
        carry = 1'b1;
        for (int p = RANK - 1; p >= 0; p--) begin
            if (carry) begin
                if (r[p] == DIG_W'(DIMENSION - 1)) begin
                    r[p] = '0;
                end else begin
                    r[p]  = r[p] + 1'b1;
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [ROT_AW-1:0] rot_addr(input logic [DIG_W-1:0] row,
                                                   input logic [DIG_W-1:0] col);
        return ROT_AW'(ROT_AW'(row) * ROT_AW'(DIMENSION) + ROT_AW'(col));
    endfunction

    function automatic logic [VAL_W-1:0] mag32(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (VAL_W'(0) - v) : v;
    endfunction

endpackage

/* sv/fourth_rank_tensor_rotation_core.sv */
// Top level of the fourth-rank tensor rotation core.
`timescale 1ns / 1ps
`include "fourth_rank_tensor_rotation_core_macros.svh"
// Holds a 3x3 rotation (Q2.30) and a 3x3x3x3 source tensor (Q16.16) and returns one
// rotated element per read request. A read first waits in a load state while the
// first operands are fetched; each source term then builds its exact five-factor product
// limb by limb on one shared 32x32 multiply-add (one load step, 1 + 2 + 3 + 4 limb steps,
// three rotation fetches, one 192-bit accumulate); a round state then rounds to Q16.16
// and clips with a flag, and a done state loads the output register once it is free.
// The input is not ready while a read runs; a finished result waits in the output
// register, so the next item can be taken meanwhile. A read outside the tensor range
// skips the terms and returns zero.
module fourth_rank_tensor_rotation_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [frtr_pkg::S_TDATA_W-1:0]    s_tdata,  // index[6:0], value[38:7], zero pad
    input  logic [frtr_pkg::S_TUSER_W-1:0]    s_tuser,  // req_type[1:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [frtr_pkg::M_TDATA_W-1:0]    m_tdata,  // result_index[6:0], result_value[38:7]
    output logic [frtr_pkg::M_TUSER_W-1:0]    m_tuser   // saturated[0]
);
    import frtr_pkg::*;

    logic [IDX_W-1:0]  in_idx;
    logic [VAL_W-1:0]  in_val;
    req_type_t         in_req;
    logic              accept;
    logic              rot_we, ten_we, start_read, oor;

    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    logic              ready, out_load, out_free;
    logic [TEN_AW-1:0] ten_rd_addr;
    logic [ROT_AW-1:0] rot_rd_addr;
    logic [VAL_W-1:0]  ten_rd_data, rot_rd_data;
    logic [VAL_W-1:0]  res_value;
    logic              res_sat;
    dp_cmd_t           cmd;

    assign in_idx   = s_tdata[IDX_W-1:0];
    assign in_val   = s_tdata[IDX_W +: VAL_W];
    assign in_req   = req_type_t'(s_tuser);
    assign accept   = s_tvalid && s_tready;
    assign oor      = (32'(in_idx) >= TEN_SIZE);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        rot_we     = 1'b0;
        ten_we     = 1'b0;
        start_read = 1'b0;
        unique case (in_req)
            REQ_ROT_WR: rot_we     = accept && (32'(in_idx) < ROT_SIZE);
            REQ_TEN_WR: ten_we     = accept && (32'(in_idx) < TEN_SIZE);
            REQ_READ:   start_read = accept;
            default:    ;
        endcase
    end

    frtr_ram #(.WIDTH(VAL_W), .DEPTH(ROT_SIZE)) u_rot_ram (
        .aclk    (aclk),
        .wr_en   (rot_we),
        .wr_addr (in_idx[ROT_AW-1:0]),
        .wr_data (in_val),
        .rd_addr (rot_rd_addr),
        .rd_data (rot_rd_data)
    );

    frtr_ram #(.WIDTH(VAL_W), .DEPTH(TEN_SIZE)) u_ten_ram (
        .aclk    (aclk),
        .wr_en   (ten_we),
        .wr_addr (in_idx[TEN_AW-1:0]),
        .wr_data (in_val),
        .rd_addr (ten_rd_addr),
        .rd_data (ten_rd_data)
    );

    frtr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_read  (start_read),
        .oor         (oor),
        .tgt_idx     (in_idx),
        .out_free    (out_free),
        .ready       (ready),
        .out_load    (out_load),
        .ten_rd_addr (ten_rd_addr),
        .rot_rd_addr (rot_rd_addr),
        .cmd         (cmd)
    );

    frtr_dp u_dp (
        .aclk        (aclk),
        .cmd         (cmd),
        .ten_rd_data (ten_rd_data),
        .rot_rd_data (rot_rd_data),
        .res_value   (res_value),
        .res_sat     (res_sat)
    );

    always_comb begin
        idx_next      = start_read ? in_idx : idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (out_load) begin
            m_tvalid_next                 = 1'b1;
            m_tdata_next                  = '0;
            m_tdata_next[IDX_W-1:0]       = idx_reg;
            m_tdata_next[IDX_W +: VAL_W]  = res_value;
            m_tuser_next                  = M_TUSER_W'(res_sat);
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `FRTR_ASSERT_IMP(a_out_no_overwrite, out_load, !m_tvalid_reg || m_tready)
    `FRTR_ASSERT_NXT(a_read_holds_off_input, start_read, !s_tready)

endmodule

/* sv/frtr_ram.sv */
// Generic memory with one write port and one registered read port.
`timescale 1ns / 1ps
module frtr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/frtr_dp.sv */
// Shared multiply-accumulate datapath: term build, wide accumulate, round and clip.
`timescale 1ns / 1ps
module frtr_dp (
    input  logic                         aclk,
    input  frtr_pkg::dp_cmd_t            cmd,
    input  logic [frtr_pkg::VAL_W-1:0]   ten_rd_data,
    input  logic [frtr_pkg::VAL_W-1:0]   rot_rd_data,
    output logic [frtr_pkg::VAL_W-1:0]   res_value,
    output logic                         res_sat
);
    import frtr_pkg::*;

    logic [TERM_LIMBS-1:0][LIMB_W-1:0] term_reg, term_next;
    logic [LIMB_W-1:0]                 carry_reg, carry_next;
    logic [LIMB_W-1:0]                 f_reg, f_next;
    logic                              sign_reg, sign_next;
    logic [ACC_W-1:0]                  acc_reg, acc_next;
    logic [VAL_W-1:0]                  res_value_reg, res_value_next;
    logic                              res_sat_reg, res_sat_next;

    logic [LIMB_W-1:0]   term_sel;
    logic [LIMB_W-1:0]   carry_in;
    logic [2*LIMB_W-1:0] mul_full;
    logic [2*LIMB_W-1:0] mac_sum;
    logic [HI_W-1:0]     hi_sum;
    logic                fits;

    always_comb begin
        term_sel = term_reg[cmd.limb];
        carry_in = (cmd.limb == '0) ? '0 : carry_reg;
        mul_full = term_sel * f_reg;
        mac_sum  = mul_full + {{LIMB_W{1'b0}}, carry_in};
        hi_sum   = acc_reg[ACC_W-1:FRAC_DROP] + HI_W'(acc_reg[FRAC_DROP-1]);
        fits     = (hi_sum[HI_W-1:VAL_W-1] == '0) || (hi_sum[HI_W-1:VAL_W-1] == '1);

        term_next      = term_reg;
        carry_next     = carry_reg;
        f_next         = f_reg;
        sign_next      = sign_reg;
        acc_next       = acc_reg;
        res_value_next = res_value_reg;
        res_sat_next   = res_sat_reg;

        if (cmd.clear) begin
            acc_next = '0;
        end
        if (cmd.init) begin
            term_next    = '0;
            term_next[0] = mag32(ten_rd_data);
            f_next       = mag32(rot_rd_data);
            sign_next    = ten_rd_data[VAL_W-1] ^ rot_rd_data[VAL_W-1];
        end
        if (cmd.fetch) begin
            f_next    = mag32(rot_rd_data);
            sign_next = sign_reg ^ rot_rd_data[VAL_W-1];
        end
        if (cmd.mul) begin
            term_next[cmd.limb] = mac_sum[LIMB_W-1:0];
            carry_next          = mac_sum[2*LIMB_W-1:LIMB_W];
            if (cmd.last_limb) begin
                term_next[LIMB_IW'(cmd.limb + 1'b1)] = mac_sum[2*LIMB_W-1:LIMB_W];
            end
        end
        if (cmd.acc) begin
            acc_next = sign_reg ? (acc_reg - ACC_W'(term_reg)) : (acc_reg + ACC_W'(term_reg));
        end
        if (cmd.round) begin
            res_sat_next   = !fits;
            res_value_next = fits ? hi_sum[VAL_W-1:0] : (hi_sum[HI_W-1] ? SAT_NEG : SAT_POS);
        end
    end

    always_ff @(posedge aclk) begin
        term_reg      <= term_next;
        carry_reg     <= carry_next;
        f_reg         <= f_next;
        sign_reg      <= sign_next;
        acc_reg       <= acc_next;
        res_value_reg <= res_value_next;
        res_sat_reg   <= res_sat_next;
    end

    assign res_value = res_value_reg;
    assign res_sat   = res_sat_reg;

endmodule

/* sv/frtr_ctrl.sv */
// Sequencer: walks source terms, factor passes and limbs of the shared multiplier.
`timescale 1ns / 1ps
`include "fourth_rank_tensor_rotation_core_macros.svh"
module frtr_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start_read,
    input  logic                          oor,
    input  logic [frtr_pkg::IDX_W-1:0]    tgt_idx,
    input  logic                          out_free,
    output logic                          ready,
    output logic                          out_load,
    output logic [frtr_pkg::TEN_AW-1:0]   ten_rd_addr,
    output logic [frtr_pkg::ROT_AW-1:0]   rot_rd_addr,
    output frtr_pkg::dp_cmd_t             cmd
);
    import frtr_pkg::*;

    state_t             state_reg, state_next;
    digits_t            tgt_reg, tgt_next;
    digits_t            src_reg, src_next;
    logic [TEN_AW-1:0]  s_reg, s_next;
    logic [PASS_W-1:0]  fp_reg, fp_next;
    logic [PASS_W-1:0]  p_reg, p_next;
    logic [LIMB_IW-1:0] n_reg, n_next;
    logic               last_reg, last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tgt_reg   <= '0;
            src_reg   <= '0;
            s_reg     <= '0;
            fp_reg    <= '0;
            p_reg     <= '0;
            n_reg     <= '0;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            tgt_reg   <= tgt_next;
            src_reg   <= src_next;
            s_reg     <= s_next;
            fp_reg    <= fp_next;
            p_reg     <= p_next;
            n_reg     <= n_next;
            last_reg  <= last_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        tgt_next      = tgt_reg;
        src_next      = src_reg;
        s_next        = s_reg;
        fp_next       = fp_reg;
        p_next        = p_reg;
        n_next        = n_reg;
        last_next     = last_reg;
        ready         = 1'b0;
        out_load      = 1'b0;
        cmd           = '0;
        cmd.limb      = n_reg;
        cmd.last_limb = (n_reg == LIMB_IW'(p_reg));

        unique case (state_reg)
            ST_IDLE: begin
                ready = 1'b1;
                if (start_read) begin
                    cmd.clear  = 1'b1;
                    tgt_next   = split_index(tgt_idx);
                    src_next   = '0;
                    s_next     = '0;
                    fp_next    = '0;
                    p_next     = '0;
                    n_next     = '0;
                    last_next  = 1'b0;
                    state_next = oor ? ST_ROUND : ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                fp_next    = fp_reg + 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
                if (cmd.last_limb) begin
                    n_next = '0;
                    if (p_reg == PASS_W'(RANK - 1)) begin
                        p_next     = '0;
                        fp_next    = '0;
                        src_next   = incr_digits(src_reg);
                        s_next     = s_reg + 1'b1;
                        last_next  = (s_reg == TEN_AW'(TEN_SIZE - 1));
                        state_next = ST_ACC;
                    end else begin
                        p_next     = p_reg + 1'b1;
                        state_next = ST_FETCH;
                    end
                end else begin
                    n_next = n_reg + 1'b1;
                end
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                fp_next    = fp_reg + 1'b1;
                state_next = ST_MUL;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = last_reg ? ST_ROUND : ST_INIT;
            end
            ST_ROUND: begin
                cmd.round  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign ten_rd_addr = s_reg;
    assign rot_rd_addr = rot_addr(tgt_reg[fp_reg], src_reg[fp_reg]);

    `FRTR_ASSERT_IMP(a_term_starts_at_first_factor, state_reg == ST_INIT, fp_reg == '0)
    `FRTR_ASSERT_IMP(a_limb_within_pass, state_reg == ST_MUL, n_reg <= LIMB_IW'(p_reg))
    `FRTR_ASSERT_IMP(a_acc_after_last_pass, state_reg == ST_ACC, $past(state_reg) == ST_MUL)

endmodule

/* tb/sv/fourth_rank_tensor_rotation_core_tb.sv */
// Self-checking testbench for the fourth-rank tensor rotation core.
`timescale 1ns / 1ps
module fourth_rank_tensor_rotation_core_tb;
    import frtr_pkg::*;

    localparam int               IDLE_PCT    = 27;
    localparam int               HOLD_CYCLES = 5000;
    localparam int               QUIET_LIMIT = 20000;
    localparam int               TAIL_CYCLES = 1300;
    localparam logic [REQ_W-1:0] REQ_UNUSED  = 2'd3;
    localparam logic [VAL_W-1:0] ONE_Q230    = 32'h4000_0000;
    localparam logic [VAL_W-1:0] HALF_Q230   = 32'h2000_0000;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] value;
        logic             sat;
    } rotated_elem_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    logic [VAL_W-1:0] rot_store    [ROT_SIZE];
    logic [VAL_W-1:0] tensor_store [TEN_SIZE];
    rotated_elem_t    expected_elems [$];
    rotated_elem_t    got_elem;
    rotated_elem_t    want_elem;

    int  errors        = 0;
    int  quiet_cycles  = 0;
    int  hold_requests = 0;
    int  holds_served  = 0;
    int  hold_left     = 0;
    bit  gaps_on       = 1'b1;

    fourth_rank_tensor_rotation_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (VAL_W'(0) - v) : v;
    endfunction

    function automatic rotated_elem_t rotate_element(input logic [IDX_W-1:0] idx);
        rotated_elem_t       res;
        logic [ACC_W-1:0]    sum;
        logic [ACC_W-1:0]    term;
        logic [VAL_W-1:0]    rv;
        logic [HI_W-VAL_W:0] hi;
        logic                neg;
        int unsigned         tgt [RANK];
        int unsigned         src [RANK];
        int unsigned         q;
        res = '{idx: idx, value: '0, sat: 1'b0};
        if (idx >= TEN_SIZE) begin
            return res;
        end
        q = idx;
        for (int p = RANK - 1; p >= 0; p--) begin
            tgt[p] = q % DIMENSION;
            q      = q / DIMENSION;
        end
        sum = '0;
        for (int e = 0; e < TEN_SIZE; e++) begin
            q = e;
            for (int p = RANK - 1; p >= 0; p--) begin
                src[p] = q % DIMENSION;
                q      = q / DIMENSION;
            end
            neg  = tensor_store[e][VAL_W-1];
            term = ACC_W'(magnitude(tensor_store[e]));
            for (int p = 0; p < RANK; p++) begin
                rv   = rot_store[tgt[p] * DIMENSION + src[p]];
                neg  = neg ^ rv[VAL_W-1];
                term = term * ACC_W'(magnitude(rv));
            end
            sum = neg ? sum - term : sum + term;
        end
        // round half up at 2^-16, then clip to Q16.16
        sum = sum + (ACC_W'(1) << (FRAC_DROP - 1));
        hi  = sum[ACC_W-1 -: HI_W - VAL_W + 1];
        if (&hi || ~|hi) begin
            res.value = sum[FRAC_DROP +: VAL_W];
        end else begin
            res.sat   = 1'b1;
            res.value = sum[ACC_W-1] ? SAT_NEG : SAT_POS;
        end
        return res;
    endfunction

    function automatic void apply_request(input logic [REQ_W-1:0] req,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [VAL_W-1:0] val);
        case (req)
            REQ_ROT_WR: begin
                if (idx < ROT_SIZE) rot_store[idx] = val;
            end
            REQ_TEN_WR: begin
                if (idx < TEN_SIZE) tensor_store[idx] = val;
            end
            REQ_READ: begin
                expected_elems.push_back(rotate_element(idx));
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] rot_value();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom();
            default: return VAL_W'($urandom_range(32'h8000_0000)) - ONE_Q230;
        endcase
    endfunction

    function automatic logic [VAL_W-1:0] ten_value();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3, 4: return r;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    task automatic send_item(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
                             input logic [VAL_W-1:0] val);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= S_TDATA_W'({val, idx});
        do @(posedge aclk); while (!s_tready);
        apply_request(req, idx, val);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_elems.size() != 0);
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) begin
            if ($urandom_range(19) == 0) begin
                send_item(REQ_READ, IDX_W'($urandom_range(127, TEN_SIZE)), $urandom());
            end else begin
                send_item(REQ_READ, IDX_W'($urandom_range(TEN_SIZE - 1)), $urandom());
            end
        end else if (pick < 50) begin
            if ($urandom_range(19) == 0) begin
                send_item(REQ_ROT_WR, IDX_W'($urandom_range(127, ROT_SIZE)), $urandom());
            end else begin
                send_item(REQ_ROT_WR, IDX_W'($urandom_range(ROT_SIZE - 1)), rot_value());
            end
        end else if (pick < 95) begin
            if ($urandom_range(19) == 0) begin
                send_item(REQ_TEN_WR, IDX_W'($urandom_range(127, TEN_SIZE)), $urandom());
            end else begin
                send_item(REQ_TEN_WR, IDX_W'($urandom_range(TEN_SIZE - 1)), ten_value());
            end
        end else begin
            send_item(REQ_UNUSED, IDX_W'($urandom_range(127)), $urandom());
        end
    endtask

    task automatic test_identity_rotation();
        for (int r = 0; r < ROT_SIZE; r++) begin
            send_item(REQ_ROT_WR, IDX_W'(r),
                      (r / DIMENSION == r % DIMENSION) ? ONE_Q230 : '0);
        end
        for (int e = 0; e < TEN_SIZE; e++) begin
            send_item(REQ_TEN_WR, IDX_W'(e), ten_value());
        end
        send_item(REQ_READ, '0, '0);
        send_item(REQ_READ, IDX_W'(TEN_SIZE / 2), '0);
        send_item(REQ_READ, IDX_W'(TEN_SIZE - 1), '1);
        drain_results();
    endtask

    task automatic test_saturation();
        send_item(REQ_ROT_WR, '0, 32'h7FFF_FFFF);
        send_item(REQ_TEN_WR, '0, 32'h7FFF_FFFF);
        send_item(REQ_READ, '0, $urandom());
        send_item(REQ_TEN_WR, '0, 32'h8000_0000);
        send_item(REQ_READ, '0, '0);
        send_item(REQ_ROT_WR, '0, 32'h8000_0000);
        send_item(REQ_READ, '0, '0);
        drain_results();
    endtask

    task automatic test_rounding();
        send_item(REQ_ROT_WR, '0, HALF_Q230);
        send_item(REQ_TEN_WR, '0, 32'd8);
        send_item(REQ_READ, '0, '0);
        send_item(REQ_TEN_WR, '0, -32'sd8);
        send_item(REQ_READ, '0, '0);
        send_item(REQ_TEN_WR, '0, -32'sd24);
        send_item(REQ_READ, '0, '0);
        drain_results();
    endtask

    task automatic test_ignored_requests();
        send_item(REQ_ROT_WR, IDX_W'(ROT_SIZE), 32'h7FFF_FFFF);
        send_item(REQ_ROT_WR, '1, 32'h8000_0000);
        send_item(REQ_TEN_WR, IDX_W'(TEN_SIZE), 32'h7FFF_FFFF);
        send_item(REQ_TEN_WR, '1, 32'h8000_0000);
        send_item(REQ_UNUSED, '0, '1);
        send_item(REQ_READ, '0, '0);
        send_item(REQ_READ, IDX_W'(TEN_SIZE), '0);
        send_item(REQ_READ, '1, '1);
        drain_results();
    endtask

    task automatic test_random_traffic(input int count, input bit gaps);
        gaps_on = gaps;
        for (int n = 0; n < count; n++) begin
            random_item();
        end
        drain_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_output_hold();
        hold_requests++;
        for (int n = 0; n < 4; n++) begin
            send_item(REQ_READ, IDX_W'($urandom_range(TEN_SIZE - 1)), '0);
            send_item(REQ_TEN_WR, IDX_W'($urandom_range(TEN_SIZE - 1)), ten_value());
        end
        drain_results();
    endtask

    task automatic test_drain_pause();
        for (int n = 0; n < 20; n++) begin
            random_item();
        end
        drain_results();
        send_item(REQ_READ, IDX_W'($urandom_range(TEN_SIZE - 1)), '0);
        for (int n = 0; n < 20; n++) begin
            random_item();
        end
        drain_results();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_elem.idx   = m_tdata[IDX_W-1:0];
                got_elem.value = m_tdata[IDX_W +: VAL_W];
                got_elem.sat   = m_tuser[0];
                if (expected_elems.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: index %0d value %h saturated %0d",
                             $time, got_elem.idx, got_elem.value, got_elem.sat);
                end else begin
                    want_elem = expected_elems.pop_front();
                    if (got_elem.idx != want_elem.idx) begin
                        errors++;
                        $display("%0t: result_index expected %0d actual %0d",
                                 $time, want_elem.idx, got_elem.idx);
                    end
                    if (got_elem.value != want_elem.value) begin
                        errors++;
                        $display("%0t: result_value (index %0d) expected %h actual %h",
                                 $time, want_elem.idx, want_elem.value, got_elem.value);
                    end
                    if (got_elem.sat != want_elem.sat) begin
                        errors++;
                        $display("%0t: saturated (index %0d) expected %0d actual %0d",
                                 $time, want_elem.idx, want_elem.sat, got_elem.sat);
                    end
                end
            end
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        foreach (rot_store[r]) rot_store[r] = '0;
        foreach (tensor_store[e]) tensor_store[e] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        test_identity_rotation();
        test_saturation();
        test_rounding();
        test_ignored_requests();
        test_random_traffic(900, 1'b1);
        test_random_traffic(200, 1'b0);
        test_output_hold();
        test_drain_pause();
        test_random_traffic(250, 1'b1);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
